// ===== src/atmf_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt median filter.
// No dependencies; every other source file imports this package.
package atmf_pkg;

	localparam int AXES         = 3;
	localparam int HIST_DEPTH   = 3;
	localparam int DIV_STEPS    = 16;
	localparam int ROOT_STEPS   = 30;
	localparam int CORDIC_STEPS = 20;
	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	localparam logic [14:0] ANGLE_MAX = 15'd9000;

	// configuration register indexes
	localparam logic [1:0] CFG_SCALE_DIVISOR  = 2'd0;
	localparam logic [1:0] CFG_DEADBAND_LIMIT = 2'd1;

	// reset values of the configuration registers
	localparam logic [15:0] SCALE_RESET    = 16'd16;
	localparam logic [14:0] DEADBAND_RESET = 15'd32;

	// filtered sample handed from front to back
	typedef struct packed {
		logic signed [16:0] fx;
		logic signed [16:0] fy;
		logic signed [16:0] fz;
	} filt_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_LOAD,
		FR_DIV,
		FR_STORE,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		TL_IDLE,
		TL_SQUARE,
		TL_SUM,
		TL_ROOT,
		TL_ROT,
		TL_FINISH,
		TL_DONE
	} tl_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_WAIT
	} bk_state_t;

	// atan(2^-i) in 1/1024 hundredths of a degree
	function automatic logic [22:0] atan_entry(input logic [4:0] idx);
		logic [22:0] r;
		unique case (idx)
			5'd0:  r = 23'd4608000;
			5'd1:  r = 23'd2720261;
			5'd2:  r = 23'd1437311;
			5'd3:  r = 23'd729602;
			5'd4:  r = 23'd366217;
			5'd5:  r = 23'd183287;
			5'd6:  r = 23'd91666;
			5'd7:  r = 23'd45836;
			5'd8:  r = 23'd22918;
			5'd9:  r = 23'd11459;
			5'd10: r = 23'd5730;
			5'd11: r = 23'd2865;
			5'd12: r = 23'd1432;
			5'd13: r = 23'd716;
			5'd14: r = 23'd358;
			5'd15: r = 23'd179;
			5'd16: r = 23'd90;
			5'd17: r = 23'd45;
			5'd18: r = 23'd22;
			5'd19: r = 23'd11;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

	// magnitude of a 17-bit signed value, range 0..32768
	function automatic logic [15:0] abs17(input logic signed [16:0] v);
		logic [16:0] m;
		m = v[16] ? 17'(-v) : 17'(v);
		return m[15:0];
	endfunction

endpackage

// ===== src/atmf_fifo.sv =====
// Two-entry queue of filtered samples between front and back.
// Depends on atmf_pkg.
module atmf_fifo import atmf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  filt_t wdata,
	output logic  full,
	input  logic  rd,
	output filt_t rdata,
	output logic  empty
);

	filt_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_wr, do_rd;

	assign full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== src/atmf_front.sv =====
// Front end: config registers, sign/magnitude split, deadband, shared divider,
// per-axis history and median. Depends on atmf_pkg.
module atmf_front import atmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [15:0] x_raw,
	input  logic [15:0] y_raw,
	input  logic [15:0] z_raw,
	output logic        q_wr,
	output filt_t       q_data,
	input  logic        q_full
);

	fr_state_t          st_q, st_d;
	logic [15:0]        scale_q;
	logic [14:0]        dead_q;
	logic [15:0]        raw_q [AXES];
	logic signed [16:0] hist_q [AXES][HIST_DEPTH];
	logic [1:0]         slot_q, axis_q;
	logic [1:0]         slot_eff, slot_nxt;
	logic [3:0]         cnt_q;
	logic [15:0]        dq_q, rm_q;
	logic               neg_q;
	logic [15:0]        divisor, mag, mag_db;
	logic [16:0]        rmt;
	logic               ge;
	logic signed [16:0] qv, sval;
	logic signed [16:0] mx, my, mz;

	function automatic logic signed [16:0] med3(input logic signed [16:0] a,
		input logic signed [16:0] b, input logic signed [16:0] c);
		logic signed [16:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	// magnitude of the axis now at the head of the raw line
	assign divisor = (scale_q == '0) ? 16'd1 : scale_q;
	assign mag     = raw_q[0][15] ? (16'h8000 - {1'b0, raw_q[0][14:0]}) : raw_q[0];
	assign mag_db  = (mag < {1'b0, dead_q}) ? 16'd0 : mag;

	// one restoring divide step
	assign rmt = {rm_q, dq_q[15]};
	assign ge  = (rmt >= {1'b0, divisor});

	// stored value: sign inverted against the raw word
	assign qv   = $signed({1'b0, dq_q});
	assign sval = neg_q ? qv : -qv;

	assign slot_eff = (slot_q < 2'(HIST_DEPTH)) ? slot_q : 2'd0;
	assign slot_nxt = (slot_eff == 2'(HIST_DEPTH - 1)) ? 2'd0 : slot_eff + 2'd1;

	// medians of the three histories
	assign mx = med3(hist_q[0][0], hist_q[0][1], hist_q[0][2]);
	assign my = med3(hist_q[1][0], hist_q[1][1], hist_q[1][2]);
	assign mz = med3(hist_q[2][0], hist_q[2][1], hist_q[2][2]);
	assign q_data.fx = (mx == '0) ? 17'sd1 : mx;
	assign q_data.fy = my;
	assign q_data.fz = mz;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FR_IDLE;
		else st_q <= st_d;
	end

	// next state and outputs
	always_comb begin
		st_d = st_q;
		full = 1'b1;
		q_wr = 1'b0;
		unique case (st_q)
			FR_IDLE: begin
				full = 1'b0;
				if (push) st_d = FR_LOAD;
			end
			FR_LOAD: st_d = FR_DIV;
			FR_DIV: begin
				if (cnt_q == 4'(DIV_STEPS - 1)) st_d = FR_STORE;
			end
			FR_STORE: begin
				if (axis_q == 2'(AXES - 1)) st_d = FR_PUSH;
				else st_d = FR_LOAD;
			end
			FR_PUSH: begin
				if (!q_full) begin
					q_wr = 1'b1;
					st_d = FR_IDLE;
				end
			end
			default: st_d = FR_IDLE;
		endcase
	end

	// config, history and slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			dead_q  <= DEADBAND_RESET;
			slot_q  <= '0;
			axis_q  <= '0;
			for (int a = 0; a < AXES; a++)
				for (int s = 0; s < HIST_DEPTH; s++)
					hist_q[a][s] <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_SCALE_DIVISOR) scale_q <= cfg_wdata;
			if (cfg_we && cfg_index == CFG_DEADBAND_LIMIT) dead_q <= cfg_wdata[14:0];
			if (st_q == FR_STORE) begin
				hist_q[axis_q][slot_eff] <= sval;
				if (axis_q == 2'(AXES - 1)) begin
					axis_q <= '0;
					slot_q <= slot_nxt;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
		end
	end

	// raw line and divider datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			FR_IDLE: begin
				if (push) begin
					raw_q[0] <= x_raw;
					raw_q[1] <= y_raw;
					raw_q[2] <= z_raw;
				end
			end
			FR_LOAD: begin
				dq_q  <= mag_db;
				rm_q  <= '0;
				neg_q <= raw_q[0][15];
				cnt_q <= '0;
			end
			FR_DIV: begin
				rm_q  <= ge ? 16'(rmt - {1'b0, divisor}) : rmt[15:0];
				dq_q  <= {dq_q[14:0], ge};
				cnt_q <= cnt_q + 4'd1;
			end
			FR_STORE: begin
				raw_q[0] <= raw_q[1];
				raw_q[1] <= raw_q[2];
			end
			default: ;
		endcase
	end

endmodule

// ===== src/atmf_tilt.sv =====
// One tilt lane: squares, bit-pair integer square root, 20-step vectoring CORDIC.
// Depends on atmf_pkg.
module atmf_tilt import atmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] v,
	input  logic signed [16:0] a,
	input  logic signed [16:0] b,
	output logic               done,
	output logic signed [14:0] res
);

	tl_state_t          st_q, st_d;
	logic               vneg_q, vzero_q;
	logic [15:0]        vmag_q, ma_q, mb_q;
	logic [31:0]        sqa_q, sqb_q, sum;
	logic [59:0]        rad_q;
	logic [32:0]        rem_q, remt, trial;
	logic [29:0]        root_q;
	logic               rge;
	logic signed [33:0] px_q, py_q, dx, dy;
	logic signed [25:0] acc_q, tab;
	logic [4:0]         cnt_q;
	logic signed [14:0] res_q;
	logic [24:0]        acc_pos;
	logic [25:0]        hsum;
	logic [15:0]        h16;
	logic [14:0]        h15;

	assign done = (st_q == TL_DONE);
	assign res  = res_q;
	assign sum  = sqa_q + sqb_q;

	// square root step
	assign remt  = {rem_q[30:0], rad_q[59:58]};
	assign trial = {1'b0, root_q, 2'b01};
	assign rge   = (remt >= trial);

	// rotation step
	assign dx  = py_q >>> cnt_q;
	assign dy  = px_q >>> cnt_q;
	assign tab = $signed({3'b000, atan_entry(cnt_q)});

	// rounding and clamp of the final angle
	assign acc_pos = acc_q[25] ? 25'd0 : acc_q[24:0];
	assign hsum    = {1'b0, acc_pos} + 26'd512;
	assign h16     = hsum[25:10];
	assign h15     = (h16 > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : h16[14:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= TL_IDLE;
		else st_q <= st_d;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			TL_IDLE:   if (start) st_d = TL_SQUARE;
			TL_SQUARE: st_d = TL_SUM;
			TL_SUM: begin
				if (vzero_q || sum == '0) st_d = TL_DONE;
				else st_d = TL_ROOT;
			end
			TL_ROOT:   if (cnt_q == 5'(ROOT_STEPS - 1)) st_d = TL_ROT;
			TL_ROT:    if (cnt_q == 5'(CORDIC_STEPS - 1)) st_d = TL_FINISH;
			TL_FINISH: st_d = TL_DONE;
			TL_DONE:   st_d = TL_IDLE;
			default:   st_d = TL_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			TL_IDLE: begin
				if (start) begin
					vneg_q  <= v[16];
					vzero_q <= (v == '0);
					vmag_q  <= abs17(v);
					ma_q    <= abs17(a);
					mb_q    <= abs17(b);
				end
			end
			TL_SQUARE: begin
				sqa_q <= ma_q * ma_q;
				sqb_q <= mb_q * mb_q;
			end
			TL_SUM: begin
				rad_q  <= {sum, 28'd0};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				if (vzero_q) res_q <= '0;
				else if (vneg_q) res_q <= -$signed(ANGLE_MAX);
				else res_q <= $signed(ANGLE_MAX);
			end
			TL_ROOT: begin
				rad_q  <= {rad_q[57:0], 2'b00};
				rem_q  <= rge ? (remt - trial) : remt;
				root_q <= {root_q[28:0], rge};
				if (cnt_q == 5'(ROOT_STEPS - 1)) begin
					cnt_q <= '0;
					px_q  <= $signed({4'b0000, root_q[28:0], rge});
					py_q  <= $signed({4'b0000, vmag_q, 14'd0});
					acc_q <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			TL_ROT: begin
				if (py_q > 0) begin
					px_q  <= px_q + dx;
					py_q  <= py_q - dy;
					acc_q <= acc_q + tab;
				end else begin
					px_q  <= px_q - dx;
					py_q  <= py_q + dy;
					acc_q <= acc_q - tab;
				end
				cnt_q <= cnt_q + 5'd1;
			end
			TL_FINISH: res_q <= vneg_q ? -$signed(h15) : $signed(h15);
			default: ;
		endcase
	end

endmodule

// ===== src/atmf_back.sv =====
// Back end: takes filtered samples off the queue, runs both tilt lanes and
// holds the result beat. Depends on atmf_pkg and atmf_tilt.
module atmf_back import atmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  filt_t              q_data,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output logic signed [14:0] angle_from_y,
	output logic signed [14:0] angle_from_x,
	output logic [15:0]        abs_x,
	output logic [15:0]        abs_y,
	output logic [15:0]        abs_z
);

	bk_state_t          st_q, st_d;
	logic               y_done, x_done, y_seen_q, x_seen_q;
	logic signed [14:0] y_res, x_res;
	logic               out_vld_q, load;
	logic [15:0]        ax_q, ay_q, az_q;

	atmf_tilt u_tilt_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_rd),
		.v      (q_data.fy),
		.a      (q_data.fx),
		.b      (q_data.fz),
		.done   (y_done),
		.res    (y_res)
	);

	atmf_tilt u_tilt_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_rd),
		.v      (q_data.fx),
		.a      (q_data.fy),
		.b      (q_data.fz),
		.done   (x_done),
		.res    (x_res)
	);

	assign empty = !out_vld_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// next state and outputs
	always_comb begin
		st_d = st_q;
		q_rd = 1'b0;
		load = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					st_d = BK_RUN;
				end
			end
			BK_RUN: if (y_seen_q && x_seen_q) st_d = BK_WAIT;
			BK_WAIT: begin
				if (!out_vld_q) begin
					load = 1'b1;
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	// lane completion flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_seen_q  <= 1'b0;
			x_seen_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_rd) begin
				y_seen_q <= 1'b0;
				x_seen_q <= 1'b0;
			end else begin
				if (y_done) y_seen_q <= 1'b1;
				if (x_done) x_seen_q <= 1'b1;
			end
			if (load) out_vld_q <= 1'b1;
			else if (pop) out_vld_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (q_rd) begin
			ax_q <= abs17(q_data.fx);
			ay_q <= abs17(q_data.fy);
			az_q <= abs17(q_data.fz);
		end
		if (load) begin
			angle_from_y <= y_res;
			angle_from_x <= x_res;
			abs_x        <= ax_q;
			abs_y        <= ay_q;
			abs_z        <= az_q;
		end
	end

`ifndef ASSERT_OFF
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(y_done || x_done) |-> (st_q == BK_RUN))
		else $error("tilt lane finished outside run state");

	a_wait_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_WAIT && !out_vld_q) |=> (st_q == BK_IDLE && out_vld_q))
		else $error("free result register not loaded");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (angle_from_y <= 15'sd9000 && angle_from_y >= -15'sd9000
			&& angle_from_x <= 15'sd9000 && angle_from_x >= -15'sd9000))
		else $error("angle out of range");
`endif

endmodule

// ===== src/accel_tilt_median_filter.sv =====
// Top level of the accelerometer tilt median filter: front, queue and back.
// Depends on atmf_pkg, atmf_front, atmf_fifo and atmf_back.
//
//  channel   ports                                   beat taken when
//  config    cfg_we, cfg_index, cfg_wdata            cfg_we high
//  sample    push, full, x_raw, y_raw, z_raw          push && !full
//  result    pop, empty, angle_from_*, abs_*          pop && !empty
//
// Per sample, the front runs a 16-step divider once per axis, plus accept and
// hand-off; the back runs a 30-step square root and 20-step CORDIC in two
// parallel lanes.
// Reset clears config to defaults, histories to zero and all queues to empty.
// A two-entry queue lets the front take new samples while the back or an
// unread result stalls.
module accel_tilt_median_filter import atmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        x_raw,
	input  logic [15:0]        y_raw,
	input  logic [15:0]        z_raw,
	output logic               empty,
	input  logic               pop,
	output logic signed [14:0] angle_from_y,
	output logic signed [14:0] angle_from_x,
	output logic [15:0]        abs_x,
	output logic [15:0]        abs_y,
	output logic [15:0]        abs_z
);

	logic  f_wr, f_full, f_rd, f_empty;
	filt_t f_wdata, f_rdata;

	atmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.x_raw     (x_raw),
		.y_raw     (y_raw),
		.z_raw     (z_raw),
		.q_wr      (f_wr),
		.q_data    (f_wdata),
		.q_full    (f_full)
	);

	atmf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_wr),
		.wdata  (f_wdata),
		.full   (f_full),
		.rd     (f_rd),
		.rdata  (f_rdata),
		.empty  (f_empty)
	);

	atmf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (f_empty),
		.q_data       (f_rdata),
		.q_rd         (f_rd),
		.empty        (empty),
		.pop          (pop),
		.angle_from_y (angle_from_y),
		.angle_from_x (angle_from_x),
		.abs_x        (abs_x),
		.abs_y        (abs_y),
		.abs_z        (abs_z)
	);

endmodule
